### sv/matrix_multiply_assert.svh
// Assertion macros for the matrix multiply RTL.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH
`ifndef SYNTHESIS
`define MM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define MM_ASSERT(lbl, prop, msg)
`define MM_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

### sv/mm_pkg.sv
// Types and constants shared by the matrix multiply modules.
`timescale 1ns / 1ps
`default_nettype none
package mm_pkg;

  localparam int REQ_W     = 2;
  localparam int ROW_W     = 3;
  localparam int VAL_W     = 32;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int PROD_W = 64;
  localparam int FRAC_W = 16;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int ACC_W  = 52;

  localparam logic [DIM_W-1:0] A_ROWS_RST     = 4'd2;
  localparam logic [DIM_W-1:0] INNER_SIZE_RST = 4'd2;
  localparam logic [DIM_W-1:0] B_COLS_RST     = 4'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE_A = 2'd0,
    REQ_WRITE_B = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS     = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_B_COLS     = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_COMPUTE
  } cmd_op_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic [ROW_W-1:0]        row_index;
    logic [ROW_W-1:0]        col_index;
    logic signed [VAL_W-1:0] element_value;
  } req_t;

  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic [ROW_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } res_t;

  // Effective (clamped) dimensions.
  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] inner_size;
    logic [DIM_W-1:0] b_cols;
  } dims_t;

  typedef struct packed {
    cmd_op_e                 op;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage
`default_nettype wire

### sv/mm_front.sv
// Front end: configuration registers, request checking and queue push.
`timescale 1ns / 1ps
`default_nettype none
module mm_front import mm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire req_t                 req_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i,
  input  wire qstat_t               qstat_i,
  output dims_t                     dims_o,
  output logic                      push_o,
  output cmd_t                      cmd_o
);

  logic [DIM_W-1:0] a_rows_q, inner_size_q, b_cols_q;
  logic             cmd_ok;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q     <= A_ROWS_RST;
      inner_size_q <= INNER_SIZE_RST;
      b_cols_q     <= B_COLS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_A_ROWS:     a_rows_q     <= cfg_data_i;
        CFG_INNER_SIZE: inner_size_q <= cfg_data_i;
        CFG_B_COLS:     b_cols_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dims_o.a_rows     = eff_dim(a_rows_q);
  assign dims_o.inner_size = eff_dim(inner_size_q);
  assign dims_o.b_cols     = eff_dim(b_cols_q);

  // Classify the request; drop out-of-range loads and unknown codes.
  always_comb begin
    cmd_ok       = 1'b0;
    cmd_o.op     = CMD_COMPUTE;
    cmd_o.row    = req_i.row_index;
    cmd_o.col    = req_i.col_index;
    cmd_o.value  = req_i.element_value;
    unique case (req_type_e'(req_i.req_type))
      REQ_WRITE_A: begin
        cmd_o.op = CMD_LOAD_A;
        cmd_ok   = (DIM_W'(req_i.row_index) < dims_o.a_rows) &&
                   (DIM_W'(req_i.col_index) < dims_o.inner_size);
      end
      REQ_WRITE_B: begin
        cmd_o.op = CMD_LOAD_B;
        cmd_ok   = (DIM_W'(req_i.row_index) < dims_o.inner_size) &&
                   (DIM_W'(req_i.col_index) < dims_o.b_cols);
      end
      REQ_COMPUTE: begin
        cmd_o.op = CMD_COMPUTE;
        cmd_ok   = 1'b1;
      end
      default: ;
    endcase
  end

  assign push_o = start_i && !qstat_i.full && cmd_ok;

endmodule
`default_nettype wire

### sv/mm_queue.sv
// Short command queue between the front end and the execution unit.
`timescale 1ns / 1ps
`default_nettype none
module mm_queue import mm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output qstat_t    qstat_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  assign head_o        = slot_q[rd_ptr_q];
  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));

endmodule
`default_nettype wire

### sv/mm_back.sv
// Execution unit: element stores, loop sequencer and pipelined MAC.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_multiply_assert.svh"
module mm_back import mm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire dims_t dims_i,
  input  wire logic  empty_i,
  input  wire cmd_t  head_i,
  output logic       pop_o,
  output res_t       res_o,
  output logic       res_strobe_o
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-VAL_W){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-VAL_W){1'b1}}, 32'h8000_0000};

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic             first;
    logic             lastk;
    logic             last;
  } tag_t;

  logic signed [VAL_W-1:0] a_mem [DEPTH];
  logic signed [VAL_W-1:0] b_mem [DEPTH];

  back_state_e state_q, state_d;
  logic [ROW_W-1:0] i_q, j_q, k_q;
  logic             a_we, b_we, issue;
  logic             last_k, last_i, last_j, last_all;
  logic [ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;
  tag_t             issue_tag;

  logic                    s1_valid_q, s2_valid_q;
  tag_t                    s1_tag_q, s2_tag_q;
  logic signed [VAL_W-1:0] a_rd_q, b_rd_q;
  logic signed [PROD_W-1:0] prod_q, prod_d, rnd;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_q, sum_d;
  logic signed [VAL_W-1:0]  sat_val;
  res_t                     res_q;
  logic                     res_strobe_q;

  assign last_k   = (DIM_W'(k_q) == dims_i.inner_size - DIM_W'(1));
  assign last_i   = (DIM_W'(i_q) == dims_i.a_rows - DIM_W'(1));
  assign last_j   = (DIM_W'(j_q) == dims_i.b_cols - DIM_W'(1));
  assign last_all = last_k && last_i && last_j;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i && head_i.op == CMD_COMPUTE) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (last_all) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    a_we  = 1'b0;
    b_we  = 1'b0;
    issue = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        pop_o = !empty_i;
        a_we  = !empty_i && head_i.op == CMD_LOAD_A;
        b_we  = !empty_i && head_i.op == CMD_LOAD_B;
      end
      BK_RUN: issue = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk k fastest, then rows, then columns.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (!issue) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (!last_k) begin
      k_q <= k_q + ROW_W'(1);
    end else begin
      k_q <= '0;
      if (!last_i) begin
        i_q <= i_q + ROW_W'(1);
      end else begin
        i_q <= '0;
        j_q <= j_q + ROW_W'(1);
      end
    end
  end

  assign wr_addr   = ADDR_W'(int'(head_i.row) * MAX_DIM + int'(head_i.col));
  assign a_rd_addr = ADDR_W'(int'(i_q) * MAX_DIM + int'(k_q));
  assign b_rd_addr = ADDR_W'(int'(k_q) * MAX_DIM + int'(j_q));

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[wr_addr] <= head_i.value;
    end
    a_rd_q <= a_mem[a_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[wr_addr] <= head_i.value;
    end
    b_rd_q <= b_mem[b_rd_addr];
  end

  assign issue_tag.row   = i_q;
  assign issue_tag.col   = j_q;
  assign issue_tag.first = (k_q == '0);
  assign issue_tag.lastk = last_k;
  assign issue_tag.last  = last_all;

  assign prod_d = a_rd_q * b_rd_q;

  // Round half up: add half an LSB, then floor by dropping the fraction.
  assign rnd   = prod_q + 64'sd32768;
  assign term  = rnd[PROD_W-1:FRAC_W];
  assign sum_d = (s2_tag_q.first ? '0 : acc_q) + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};

  always_comb begin
    if (sum_d > SAT_HI) begin
      sat_val = SAT_HI[VAL_W-1:0];
    end else if (sum_d < SAT_LO) begin
      sat_val = SAT_LO[VAL_W-1:0];
    end else begin
      sat_val = sum_d[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      s1_valid_q   <= issue;
      s2_valid_q   <= s1_valid_q;
      res_strobe_q <= s2_valid_q && s2_tag_q.lastk;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= issue_tag;
    s2_tag_q <= s1_tag_q;
    prod_q   <= prod_d;
    if (s2_valid_q) begin
      acc_q <= sum_d;
    end
    if (s2_valid_q && s2_tag_q.lastk) begin
      res_q.out_row   <= s2_tag_q.row;
      res_q.out_col   <= s2_tag_q.col;
      res_q.out_value <= sat_val;
      res_q.last      <= s2_tag_q.last;
    end
  end

  assign res_o        = res_q;
  assign res_strobe_o = res_strobe_q;

  `MM_ASSERT_IMPL(a_pop_only_idle, pop_o, state_q == BK_IDLE, "queue popped while computing")
  `MM_ASSERT_IMPL(a_no_load_in_run, state_q == BK_RUN, !a_we && !b_we, "store written mid-compute")
  `MM_ASSERT_IMPL(a_k_in_range, state_q == BK_RUN, DIM_W'(k_q) < dims_i.inner_size,
                  "inner index past dimension")
  `MM_ASSERT(a_res_from_tail, !res_strobe_q || $past(s2_valid_q && s2_tag_q.lastk),
             "result without a finished sum")

endmodule
`default_nettype wire

### sv/matrix_multiply.sv
// Top level of the dense matrix multiply engine.
`timescale 1ns / 1ps
`default_nettype none
// Loads A and B elements and, on a compute request, streams the product in
// column-major order. A request is taken whenever busy is low; busy rises
// only while the four-entry request queue is full. Each load is written to
// its store when popped; a compute runs the single MAC at one product term
// per cycle over a_rows * inner_size * b_cols terms, and results pass the
// read, product and output registers behind the terms that finish them.
// Results appear on res_o for one cycle each, marked by res_strobe_o; the
// receiver cannot stall them, so it must take every strobed result. The
// element stores are not cleared by reset; compute only over elements
// that were loaded. Change configuration only while the block is idle.
module matrix_multiply import mm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire req_t                 req_i,
  output res_t                      res_o,
  output logic                      res_strobe_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i
);

  dims_t  dims;
  qstat_t qstat;
  cmd_t   push_cmd, head;
  logic   push, pop;

  assign busy        = qstat.full;
  assign cfg_ready_o = 1'b1;

  mm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .qstat_i     (qstat),
    .dims_o      (dims),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  mm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  mm_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dims_i       (dims),
    .empty_i      (qstat.empty),
    .head_i       (head),
    .pop_o        (pop),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule
`default_nettype wire

### verif/matrix_multiply_checker.sv
// Checker for the matrix multiply engine: predicts every product element and compares it.
`timescale 1ns / 1ps
module matrix_multiply_checker import mm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  req_t                 req_i,
  input  res_t                 res_i,
  input  logic                 res_strobe_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  output int                   err_count_o,
  output int                   pending_o
);

  localparam int DIM_MAX = 8;

  logic [DIM_W-1:0]        rows_reg;
  logic [DIM_W-1:0]        inner_reg;
  logic [DIM_W-1:0]        cols_reg;
  logic signed [VAL_W-1:0] a_elems [DIM_MAX*DIM_MAX];
  logic signed [VAL_W-1:0] b_elems [DIM_MAX*DIM_MAX];
  res_t                    product_q [$];

  int     dim_m, dim_n, dim_q;
  int     i, j, k;
  longint acc;
  res_t   elem;
  res_t   want;

  // Zero reads as one, anything above the array size as the array size.
  function automatic int clamp_dim(logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > DIM_MAX) return DIM_MAX;
    return int'(raw);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_reg    = A_ROWS_RST;
      inner_reg   = INNER_SIZE_RST;
      cols_reg    = B_COLS_RST;
      err_count_o = 0;
      product_q.delete();
    end else begin
      if (res_strobe_i) begin
        if (product_q.size() == 0) begin
          $error("product element row %0d col %0d arrived with nothing outstanding",
                 res_i.out_row, res_i.out_col);
          err_count_o++;
        end else begin
          want = product_q.pop_front();
          if (res_i.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, res_i.out_row);
            err_count_o++;
          end
          if (res_i.out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, res_i.out_col);
            err_count_o++;
          end
          if (res_i.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d",
                   $signed(want.out_value), $signed(res_i.out_value));
            err_count_o++;
          end
          if (res_i.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res_i.last);
            err_count_o++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_A_ROWS:     rows_reg  = cfg_data_i;
          CFG_INNER_SIZE: inner_reg = cfg_data_i;
          CFG_B_COLS:     cols_reg  = cfg_data_i;
          default: ;
        endcase
      end

      if (start && !busy) begin
        dim_m = clamp_dim(rows_reg);
        dim_n = clamp_dim(inner_reg);
        dim_q = clamp_dim(cols_reg);
        case (req_i.req_type)
          REQ_WRITE_A: begin
            if (req_i.row_index < dim_m && req_i.col_index < dim_n)
              a_elems[int'(req_i.row_index) * DIM_MAX + int'(req_i.col_index)] =
                req_i.element_value;
          end
          REQ_WRITE_B: begin
            if (req_i.row_index < dim_n && req_i.col_index < dim_q)
              b_elems[int'(req_i.row_index) * DIM_MAX + int'(req_i.col_index)] =
                req_i.element_value;
          end
          REQ_COMPUTE: begin
            // Column-major walk over the product.
            for (j = 0; j < dim_q; j++) begin
              for (i = 0; i < dim_m; i++) begin
                acc = 0;
                for (k = 0; k < dim_n; k++)
                  // round half up: floor of (a*b + 2^15) / 2^16
                  acc += (longint'(a_elems[i*DIM_MAX+k]) * longint'(b_elems[k*DIM_MAX+j])
                          + 64'sd32768) >>> FRAC_W;
                elem.out_row = ROW_W'(i);
                elem.out_col = ROW_W'(j);
                if (acc > 64'sd2147483647)
                  elem.out_value = 32'h7fff_ffff;
                else if (acc < -64'sd2147483648)
                  elem.out_value = 32'h8000_0000;
                else
                  elem.out_value = acc[VAL_W-1:0];
                elem.last = (j == dim_q - 1) && (i == dim_m - 1);
                product_q.push_back(elem);
              end
            end
          end
          default: ;
        endcase
      end
    end
    pending_o = product_q.size();
  end

endmodule

### verif/matrix_multiply_tb.sv
// Testbench top for the matrix multiply engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module matrix_multiply_tb;
  import mm_pkg::*;

  localparam int DIM_MAX       = 8;
  localparam int RANDOM_ITEMS  = 200;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic [REQ_W-1:0]     REQ_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  req_t                 req_i;
  res_t                 res_o;
  logic                 res_strobe_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_data_i;
  int                   err_count;
  int                   pending;

  // Effective geometry as the block sees it, and which store entries hold data.
  int rows_eff  = int'(A_ROWS_RST);
  int inner_eff = int'(INNER_SIZE_RST);
  int cols_eff  = int'(B_COLS_RST);
  bit a_loaded [DIM_MAX*DIM_MAX];
  bit b_loaded [DIM_MAX*DIM_MAX];
  int items_done;

  always #5 clk_i = ~clk_i;

  matrix_multiply #(.MAX_DIM(DIM_MAX)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  matrix_multiply_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_i        (res_o),
    .res_strobe_i (res_strobe_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  function automatic int effective_dim(logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > DIM_MAX) return DIM_MAX;
    return int'(raw);
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3, 4: return VAL_W'($urandom_range(32'h0008_0000, 0)) - 32'h0004_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 13) return DIM_W'($urandom_range(15, 8));
    if (roll < 28) return DIM_W'($urandom_range(7, 4));
    return DIM_W'($urandom_range(3, 1));
  endfunction

  function automatic req_t junk_request();
    req_t r;
    r.req_type      = REQ_W'($urandom_range(3));
    r.row_index     = ROW_W'($urandom_range(7));
    r.col_index     = ROW_W'($urandom_range(7));
    r.element_value = $urandom();
    return r;
  endfunction

  function automatic req_t element(logic [REQ_W-1:0] kind, int row, int col,
                                   logic [VAL_W-1:0] value);
    req_t r;
    r.req_type      = kind;
    r.row_index     = ROW_W'(row);
    r.col_index     = ROW_W'(col);
    r.element_value = value;
    return r;
  endfunction

  function automatic req_t product_request();
    req_t r;
    r = junk_request();
    r.req_type = REQ_COMPUTE;
    return r;
  endfunction

  // A load the block must drop, or an unknown request.
  function automatic req_t stray_request();
    req_t r;
    r = junk_request();
    case ($urandom_range(2))
      0: begin
        r.req_type = REQ_WRITE_A;
        if (rows_eff < DIM_MAX)
          r.row_index = ROW_W'($urandom_range(DIM_MAX - 1, rows_eff));
        else if (inner_eff < DIM_MAX)
          r.col_index = ROW_W'($urandom_range(DIM_MAX - 1, inner_eff));
        else
          r.req_type = REQ_UNKNOWN;
      end
      1: begin
        r.req_type = REQ_WRITE_B;
        if (inner_eff < DIM_MAX)
          r.row_index = ROW_W'($urandom_range(DIM_MAX - 1, inner_eff));
        else if (cols_eff < DIM_MAX)
          r.col_index = ROW_W'($urandom_range(DIM_MAX - 1, cols_eff));
        else
          r.req_type = REQ_UNKNOWN;
      end
      default: r.req_type = REQ_UNKNOWN;
    endcase
    return r;
  endfunction

  // Hold the request until accepted, then maybe drop start for a few cycles.
  task automatic issue(req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (!(items_done >= 60 && items_done < 130) && $urandom_range(99) < 4) begin
      start <= 1'b0;
      req_i <= junk_request();
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
  endtask

  task automatic send(req_t r);
    case (r.req_type)
      REQ_WRITE_A: begin
        if (r.row_index < rows_eff && r.col_index < inner_eff) begin
          a_loaded[int'(r.row_index) * DIM_MAX + int'(r.col_index)] = 1'b1;
          items_done++;
        end
      end
      REQ_WRITE_B: begin
        if (r.row_index < inner_eff && r.col_index < cols_eff) begin
          b_loaded[int'(r.row_index) * DIM_MAX + int'(r.col_index)] = 1'b1;
          items_done++;
        end
      end
      REQ_COMPUTE: items_done++;
      default: ;
    endcase
    issue(r);
  endtask

  // Lower start, wait for every outstanding product element, then let queued loads settle.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_dims(logic [DIM_W-1:0] m, logic [DIM_W-1:0] n, logic [DIM_W-1:0] q);
    logic [CFG_IDX_W-1:0] idx  [4];
    logic [DIM_W-1:0]     data [4];
    int                   w;
    idx  = '{CFG_A_ROWS, CFG_INNER_SIZE, CFG_B_COLS, CFG_UNUSED};
    data = '{m, n, q, DIM_W'($urandom_range(15))};
    for (w = 0; w < 4; w++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[w];
      cfg_data_i  <= data[w];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    rows_eff  = effective_dim(m);
    inner_eff = effective_dim(n);
    cols_eff  = effective_dim(q);
  endtask

  // Fill every entry the next product reads, refresh some, mix in strays, shuffle.
  task automatic load_operands();
    req_t batch [$];
    req_t r;
    int   i, k, j, pick;
    for (i = 0; i < rows_eff; i++)
      for (k = 0; k < inner_eff; k++)
        if (!a_loaded[i*DIM_MAX+k] || $urandom_range(99) < 60)
          batch.push_back(element(REQ_WRITE_A, i, k, random_value()));
    for (k = 0; k < inner_eff; k++)
      for (j = 0; j < cols_eff; j++)
        if (!b_loaded[k*DIM_MAX+j] || $urandom_range(99) < 60)
          batch.push_back(element(REQ_WRITE_B, k, j, random_value()));
    repeat ($urandom_range(3)) batch.push_back(stray_request());
    while (batch.size() > 0) begin
      pick = $urandom_range(batch.size() - 1);
      r    = batch[pick];
      batch.delete(pick);
      send(r);
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $error("no verdict after %0d cycles, %0d product elements outstanding",
           CYCLE_LIMIT, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [VAL_W-1:0] corner_vals [8];
    int               j;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    items_done  = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset geometry is 2 x 2 x 8: row 2 of A is out of range.
    send(element(REQ_WRITE_A, 1, 1, 32'hffff_0000));
    send(element(REQ_WRITE_A, 2, 0, 32'h1234_5678));
    wait_drained();

    // Saturation both ways, plus drops on every bound.
    set_dims(4'd2, 4'd2, 4'd1);
    send(element(REQ_WRITE_A, 0, 0, 32'h7fff_ffff));
    send(element(REQ_WRITE_A, 0, 1, 32'h8000_0000));
    send(element(REQ_WRITE_A, 1, 0, 32'h8000_0000));
    send(element(REQ_WRITE_B, 0, 0, 32'h7fff_ffff));
    send(element(REQ_WRITE_B, 1, 0, 32'h8000_0000));
    send(element(REQ_WRITE_A, 7, 7, 32'hdead_beef));
    send(element(REQ_WRITE_A, 0, 2, 32'h0001_0000));
    send(element(REQ_WRITE_B, 7, 0, 32'h0001_0000));
    send(element(REQ_WRITE_B, 0, 7, 32'hffff_ffff));
    send(element(REQ_UNKNOWN, 7, 7, 32'hffff_ffff));
    send(product_request());
    wait_drained();

    // Zero and 15 clamp to 1 x 1 x 8; half times tiny values probes rounding.
    set_dims(4'd0, 4'd0, 4'd15);
    corner_vals = '{32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    32'h0000_0003, 32'hffff_fffd, 32'h0001_0000, 32'h5555_5555};
    send(element(REQ_WRITE_A, 0, 0, 32'h0000_8000));
    for (j = 0; j < DIM_MAX; j++)
      send(element(REQ_WRITE_B, 0, j, corner_vals[j]));
    send(product_request());

    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      wait_drained();
      set_dims(random_dim(), random_dim(), random_dim());
      repeat ($urandom_range(3, 1)) begin
        load_operands();
        send(product_request());
        if ($urandom_range(3) == 0) wait_drained();
      end
      // abandon a set of loads now and then
      if ($urandom_range(7) == 0) load_operands();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
